[hw/rtl/lru_key_cache_top_macros.svh]
// assertion helpers
`ifndef LRU_KEY_CACHE_TOP_MACROS_SVH
`define LRU_KEY_CACHE_TOP_MACROS_SVH
`define LKC_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);
`define LKC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);
`endif

[hw/rtl/lkc_pkg.sv]
package lkc_pkg;
  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DefKeyWidth = 64;
  localparam int unsigned FieldKeyW = 64;
  localparam int unsigned CfgW = 7;
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_PROBE = 2'd1;
  localparam logic [1:0] MODE_STORE = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic upd_step;
    logic clear_idx;
    logic finish;
  } lkc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic upd_last;
    logic need_update;
  } lkc_stat_t;
endpackage

[hw/rtl/lkc_ram.sv]
module lkc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/lkc_ctrl.sv]
module lkc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lkc_pkg::lkc_stat_t stat,
  output lkc_pkg::lkc_cmd_t  cmd
);
  import lkc_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRIME = 6'b000010,
    S_SCAN = 6'b000100,
    S_DECIDE = 6'b001000,
    S_UPD = 6'b010000,
    S_OUT = 6'b100000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.scan_step = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      // last compare has settled, outcome is final here
      S_DECIDE: begin
        cmd.clear_idx = 1'b1;
        state_next = stat.need_update ? S_UPD : S_OUT;
      end
      S_UPD: begin
        cmd.upd_step = 1'b1;
        if (stat.upd_last) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
endmodule

[hw/rtl/lkc_dp.sv]
module lkc_dp #(
  parameter int unsigned CAPACITY = lkc_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH = lkc_pkg::DefKeyWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lkc_pkg::CfgW-1:0]      cfg_data,
  input  logic [1:0]                    mode,
  input  logic [lkc_pkg::FieldKeyW-1:0] key,
  input  lkc_pkg::lkc_cmd_t             cmd,
  output lkc_pkg::lkc_stat_t            stat,
  output logic                          hit,
  output logic                          evicted,
  output logic [lkc_pkg::FieldKeyW-1:0] victim_key,
  output logic [lkc_pkg::CfgW-1:0]      fill_count
);
  import lkc_pkg::*;
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = AW;

  logic [CfgW-1:0] cap_reg;
  logic [CW-1:0] occ;
  logic [CAPACITY-1:0] valid;
  logic [1:0] mode_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [AW:0] idx;        // scan/update counter, one wider to reach depth
  logic [AW-1:0] rd_addr;  // entry whose data is on the ram outputs
  logic rd_ok;
  logic found, lru_found, free_found;
  logic [AW-1:0] hit_slot, lru_slot, free_slot;
  logic [KEY_WIDTH-1:0] lru_key;
  logic [RW-1:0] ref_rank;
  logic do_evict, do_insert, do_touch;
  logic [AW-1:0] ins_slot;
  logic [AW-1:0] ins_slot_r;
  logic [KEY_WIDTH-1:0] rdata;
  logic we;
  logic [RW-1:0] rank_rdata;
  logic [RW-1:0] rank_wdata;
  logic rank_we;
  logic [CW-1:0] eff_cap;

  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_reg) > CAPACITY) begin
      eff_cap = CW'(CAPACITY);
    end else begin
      eff_cap = CW'(cap_reg);
    end
  end

  lkc_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(we), .waddr(ins_slot), .wdata(key_r),
    .raddr(idx[AW-1:0]), .rdata(rdata)
  );

  lkc_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ranks (
    .clk(clk), .we(rank_we), .waddr(rd_addr), .wdata(rank_wdata),
    .raddr(idx[AW-1:0]), .rdata(rank_rdata)
  );

  assign do_insert = (mode_r == MODE_STORE) && !found;
  assign do_evict = do_insert && (occ >= eff_cap) && (occ != '0) && lru_found;
  assign do_touch = found && ((mode_r == MODE_LOOKUP) || (mode_r == MODE_STORE));
  assign ins_slot = do_evict ? lru_slot : free_slot;
  assign we = cmd.clear_idx && do_insert && (do_evict || free_found);

  assign stat.scan_last = rd_ok && (32'(rd_addr) == CAPACITY - 1);
  assign stat.upd_last = rd_ok && (32'(rd_addr) == CAPACITY - 1);
  assign stat.need_update = do_touch || (do_insert && (do_evict || free_found));

  // touch: zero the hit rank, bump valid ranks below it; insert: zero the new slot, bump every valid one
  always_comb begin
    rank_we = 1'b0;
    rank_wdata = rank_rdata + 1'b1;
    if (cmd.upd_step && rd_ok) begin
      if (do_touch) begin
        if (rd_addr == hit_slot) begin
          rank_we = 1'b1;
          rank_wdata = '0;
        end else if (valid[rd_addr] && rank_rdata < ref_rank) begin
          rank_we = 1'b1;
        end
      end else if (rd_addr == ins_slot_r) begin
        rank_we = 1'b1;
        rank_wdata = '0;
      end else if (valid[rd_addr]) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CfgW'(64);
      occ <= '0;
      valid <= '0;
      idx <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (cfg_we) cap_reg <= cfg_data;
      if (cmd.start) begin
        mode_r <= mode;
        key_r <= key[KEY_WIDTH-1:0];
        idx <= '0;
        rd_ok <= 1'b0;
        found <= 1'b0;
        lru_found <= 1'b0;
        free_found <= 1'b0;
        hit_slot <= '0;
        lru_slot <= '0;
        free_slot <= '0;
        lru_key <= '0;
      end
      if (cmd.scan_step || cmd.upd_step) begin
        idx <= idx + 1'b1;
        rd_addr <= idx[AW-1:0];
        rd_ok <= 1'b1;
      end
      if (cmd.scan_step && rd_ok) begin
        // compare entry read last cycle
        if (valid[rd_addr] && rdata == key_r && !found) begin
          found <= 1'b1;
          hit_slot <= rd_addr;
          ref_rank <= rank_rdata;
        end
        if (valid[rd_addr] && (CW'(rank_rdata) + 1'b1 == occ) && !lru_found) begin
          lru_found <= 1'b1;
          lru_slot <= rd_addr;
          lru_key <= rdata;
        end
        if (!valid[rd_addr] && !free_found) begin
          free_found <= 1'b1;
          free_slot <= rd_addr;
        end
      end
      if (cmd.clear_idx) begin
        idx <= '0;
        rd_ok <= 1'b0;
        hit <= found;
        evicted <= do_evict;
        victim_key <= do_evict ? FieldKeyW'(lru_key) : '0;
        ins_slot_r <= ins_slot;
        if (do_evict) begin
          valid[lru_slot] <= 1'b0;
          occ <= occ - 1'b1;
        end
        if (!stat.need_update) fill_count <= CfgW'(occ);
        if (!do_touch) ref_rank <= '1;
      end
      if (cmd.upd_step && rd_ok) begin
        if (!do_touch && rd_addr == ins_slot_r) valid[rd_addr] <= 1'b1;
        if (cmd.finish) begin
          if (!do_touch) begin
            occ <= occ + 1'b1;
            fill_count <= CfgW'(occ + 1'b1);
          end else begin
            fill_count <= CfgW'(occ);
          end
        end
      end
    end
  end
endmodule

[hw/rtl/lru_key_cache_top.sv]
// Fully associative LRU cache of keys. A word holds the block from its
// acceptance until its result is taken: the key RAM is scanned one entry
// per cycle, a decide state settles the outcome, then, only when the
// recency order changes, the rank RAM is rewritten one entry per cycle.
// Probe (mode 1 or 3) never changes state. The result is held on the
// outputs until taken; a new word is taken only after that.
module lru_key_cache_top #(
  parameter int unsigned CAPACITY = lkc_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH = lkc_pkg::DefKeyWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lkc_pkg::CfgW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [lkc_pkg::FieldKeyW-1:0] key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic                          evicted,
  output logic [lkc_pkg::FieldKeyW-1:0] victim_key,
  output logic [lkc_pkg::CfgW-1:0]      fill_count
);
  import lkc_pkg::*;
  lkc_cmd_t cmd;
  lkc_stat_t stat;

  lkc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  lkc_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .mode(mode), .key(key), .cmd(cmd), .stat(stat), .hit(hit),
    .evicted(evicted), .victim_key(victim_key), .fill_count(fill_count)
  );
endmodule

[hw/rtl/lkc_checker.sv]
`include "lru_key_cache_top_macros.svh"
module lkc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit,
  input logic evicted,
  input logic [63:0] victim_key
);
  `LKC_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready, "ready while result pending")
  `LKC_ASSERT_IMPL(a_evict_miss, out_valid && evicted, !hit, "eviction on a hit")
  `LKC_ASSERT_IMPL(a_zero_victim, out_valid && !evicted, victim_key == '0, "stray victim")
  `LKC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "double accept")
endmodule

bind lru_key_cache_top lkc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
  .evicted(evicted), .victim_key(victim_key)
);

[tb/tb_lru_key_cache_top.sv]
module tb_lru_key_cache_top;
  import lkc_pkg::*;

  localparam int NUM_ENTRIES = 64;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] mode;
  logic [FieldKeyW-1:0] key;
  logic out_valid;
  logic out_ready;
  logic hit;
  logic evicted;
  logic [FieldKeyW-1:0] victim_key;
  logic [CfgW-1:0] fill_count;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic [FieldKeyW-1:0] victim_key;
    logic [CfgW-1:0] fill_count;
  } lookup_result_t;

  lru_key_cache_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .key(key),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .evicted(evicted),
    .victim_key(victim_key), .fill_count(fill_count)
  );

  // predictor state
  logic [FieldKeyW-1:0] cache_key [NUM_ENTRIES];
  logic cache_valid [NUM_ENTRIES];
  int unsigned cache_rank [NUM_ENTRIES];
  int unsigned cache_fill;
  logic [CfgW-1:0] cache_cap;

  lookup_result_t pending_results[$];
  int errors;
  int idle_cycles;
  bit hold_off;
  logic [FieldKeyW-1:0] recent_keys[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic lookup_result_t predict_lookup(logic [1:0] m, logic [FieldKeyW-1:0] k);
    lookup_result_t r;
    int idx;
    int slot;
    int unsigned cap;
    int unsigned old_rank;
    idx = -1;
    slot = -1;
    r = '0;
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (idx < 0 && cache_valid[i] && cache_key[i] == k) idx = i;
    r.hit = (idx >= 0);
    if (idx >= 0) begin
      if (m == MODE_LOOKUP || m == MODE_STORE) begin
        old_rank = cache_rank[idx];
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (cache_valid[i] && cache_rank[i] < old_rank) cache_rank[i]++;
        cache_rank[idx] = 0;
      end
    end else if (m == MODE_STORE) begin
      cap = (cache_cap == 0) ? 1 : (cache_cap > NUM_ENTRIES ? NUM_ENTRIES : cache_cap);
      if (cache_fill >= cap && cache_fill > 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (slot < 0 && cache_valid[i] && cache_rank[i] == cache_fill - 1) slot = i;
        if (slot >= 0) begin
          r.evicted = 1;
          r.victim_key = cache_key[slot];
          cache_valid[slot] = 0;
          cache_fill--;
        end
      end
      if (slot < 0)
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (slot < 0 && !cache_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (cache_valid[i]) cache_rank[i]++;
        cache_key[slot] = k;
        cache_valid[slot] = 1;
        cache_rank[slot] = 0;
        cache_fill++;
      end
    end
    r.fill_count = cache_fill[CfgW-1:0];
    return r;
  endfunction

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  // sends one word and records its expected result on acceptance
  task automatic send_word(logic [1:0] m, logic [FieldKeyW-1:0] k);
    random_gap();
    mode <= m;
    key <= k;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_lookup(m, k));
    recent_keys.push_back(k);
    if (recent_keys.size() > 96) void'(recent_keys.pop_front());
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CfgW-1:0] value);
    drain();
    cfg_data <= value;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    cache_cap = value;
  endtask

  function automatic logic [FieldKeyW-1:0] pick_key();
    int s;
    s = $urandom_range(0, 9);
    if (s < 6 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (s < 9) return {$urandom, $urandom} % 80;
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    write_capacity(3);
    send_word(MODE_LOOKUP, 0);
    send_word(MODE_STORE, 0);
    send_word(MODE_STORE, '1);
    send_word(MODE_STORE, 64'h5555_aaaa_5555_aaaa);
    send_word(MODE_PROBE, 0);
    send_word(MODE_LOOKUP, 0);
    send_word(MODE_STORE, 64'haaaa_5555_aaaa_5555);
    send_word(MODE_RSVD, '1);
    send_word(MODE_PROBE, 64'h5555_aaaa_5555_aaaa);
    send_word(MODE_STORE, 64'h1);
    send_word(MODE_STORE, 64'h8000_0000_0000_0000);
    send_word(MODE_STORE, 0);
    // capacity lowered below the fill
    write_capacity(1);
    send_word(MODE_STORE, 64'h77);
    send_word(MODE_STORE, 64'h78);
    send_word(MODE_LOOKUP, 64'h78);
    write_capacity(0);
    send_word(MODE_STORE, 64'h79);
    send_word(MODE_STORE, 64'h78);
    write_capacity(127);
  endtask

  task automatic test_random(int count, logic [CfgW-1:0] cap);
    int r;
    logic [1:0] m;
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      m = (r < 50) ? MODE_STORE : (r < 80) ? MODE_LOOKUP : (r < 95) ? MODE_PROBE : MODE_RSVD;
      send_word(m, pick_key());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 6; i++) send_word(MODE_STORE, pick_key());
  endtask

  initial begin
    errors = 0;
    hold_off = 0;
    rst = 1;
    cfg_we = 0;
    cfg_data = '0;
    in_valid = 0;
    mode = '0;
    key = '0;
    cache_fill = 0;
    cache_cap = 64;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cache_valid[i] = 0;
      cache_rank[i] = 0;
      cache_key[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(300, 4);
    test_random(600, 64);
    test_random(400, 16);
    test_random(300, 1);
    test_random(330, 40);
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      n = $urandom_range(0, 9);
      out_ready <= (n < 6) || ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: hit=%0d fill=%0d", hit, fill_count);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, hit);
          errors++;
        end
        if (evicted !== exp_r.evicted) begin
          $error("evicted: expected %0d actual %0d", exp_r.evicted, evicted);
          errors++;
        end
        if (victim_key !== exp_r.victim_key) begin
          $error("victim_key: expected %h actual %h", exp_r.victim_key, victim_key);
          errors++;
        end
        if (fill_count !== exp_r.fill_count) begin
          $error("fill_count: expected %0d actual %0d", exp_r.fill_count, fill_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side and no config write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end
endmodule
